[rtl/llt_pkg.sv]
// Shared types and constants for the LCD line timing and STAT interrupt block.
// Holds the beat payload structs, the command codes and the control/status
// structs between the controller and the datapath. No dependencies.
package llt_pkg;

    localparam int SPRITE_SLOTS_DEF = 40;
    localparam int MAX_PER_LINE_DEF = 10;
    localparam int LINE_DOTS_DEF    = 456;

    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_SPRITE_WR = 2'd1;
    localparam logic [1:0] CMD_LCD_ON    = 2'd2;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam int LCDC_BG   = 0;
    localparam int LCDC_TALL = 2;
    localparam int LCDC_WIN  = 5;
    localparam int LCDC_ON   = 7;

    localparam int STAT_EN_M0   = 0;
    localparam int STAT_EN_M1   = 1;
    localparam int STAT_EN_M2   = 2;
    localparam int STAT_EN_COIN = 3;

    localparam logic [7:0] VBLANK_LINE    = 8'd144;
    localparam logic [7:0] FRAME_LINES    = 8'd154;
    localparam logic [8:0] OAM_DOTS       = 9'd80;
    localparam logic [9:0] XFER_BASE      = 10'd252;
    localparam logic [9:0] WINDOW_PENALTY = 10'd6;
    localparam logic [8:0] SPRITE_Y_OFS   = 9'd16;
    localparam logic [8:0] SPRITE_H_TALL  = 9'd16;
    localparam logic [8:0] SPRITE_H_SHORT = 9'd8;
    localparam logic [7:0] WINDOW_X_LIMIT = 8'd167;
    localparam logic [8:0] LCD_ON_DOT     = 9'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [8:0] dots;
        logic [7:0] lcd_control;
        logic [7:0] compare_line;
        logic [3:0] stat_enables;
        logic [7:0] window_y;
        logic [7:0] window_x;
        logic [7:0] bg_scroll;
        logic [5:0] sprite_index;
        logic [7:0] obj_ypos;
    } llt_in_t;

    typedef struct packed {
        logic [7:0] line;
        logic [1:0] mode;
        logic       coincidence;
        logic [8:0] dot_position;
        logic       vblank_irq;
        logic       stat_irq;
    } llt_out_t;

    typedef struct packed {
        logic ready;
        logic step;
        logic scan_start;
        logic scan_run;
        logic eval;
        logic publish;
    } llt_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic req_is_tick;
        logic over_line;
        logic need_sample;
        logic scan_done;
        logic out_free;
    } llt_stat_t;

endpackage

[rtl/llt_stream_if.sv]
// Valid/ready channel carrying one payload beat.
// The payload type is set per instance, normally a struct from llt_pkg.
interface llt_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/lcd_line_timing_and_stat_irq.sv]
// Top level of the LCD line timing and STAT interrupt block.
// Joins llt_ctrl and llt_datapath; uses llt_pkg and llt_stream_if.
//
//   Channel  Dir   Payload    Carries
//   req      in    llt_in_t   tick, sprite Y write or LCD-on command
//   rsp      out   llt_out_t  line, mode, flags, dot position, irq pulses
//
// A tick steps one line per wrap of the dots past the line end, is evaluated and published.
// A tick with the LCD on that ends on a visible line not yet sampled also
// scans the sprite Y store, one slot per cycle.
// Sprite writes, LCD-on and unused commands go straight from accept to publish.
// Reset clears all timing state; the sprite store reads as zero per slot until written.
// A stalled rsp holds its beat while the next req beat is accepted and worked on.
module lcd_line_timing_and_stat_irq
    import llt_pkg::*;
#(
    parameter int SPRITE_SLOTS = SPRITE_SLOTS_DEF,
    parameter int MAX_PER_LINE = MAX_PER_LINE_DEF,
    parameter int LINE_DOTS    = LINE_DOTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    llt_stream_if.sink   req,
    llt_stream_if.source rsp
);

    llt_cmd_t  ctl_cmd;
    llt_stat_t dp_stat;

    llt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (dp_stat),
        .cmd   (ctl_cmd)
    );

    llt_datapath #(
        .SPRITE_SLOTS (SPRITE_SLOTS),
        .MAX_PER_LINE (MAX_PER_LINE),
        .LINE_DOTS    (LINE_DOTS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (ctl_cmd),
        .stat  (dp_stat)
    );

endmodule

[rtl/llt_ctrl.sv]
// Sequencer for the LCD timing block: accept, line steps, sprite scan,
// mode evaluation and result hand-off. Uses llt_pkg command/status structs.
module llt_ctrl
    import llt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  llt_stat_t stat,
    output llt_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_SCAN,
        S_EVAL,
        S_PUBLISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = stat.req_is_tick ? S_WRAP : S_PUBLISH;
                end
            end
            S_WRAP:
            begin
                if (stat.over_line)
                begin
                    cmd.step = 1'b1;
                end
                else if (stat.need_sample)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/llt_datapath.sv]
// Datapath for the LCD timing block: line/dot state, sprite Y store with
// its scan counter, mode and STAT evaluation, and the result register.
// Depends on llt_pkg and llt_stream_if; driven by llt_ctrl.
module llt_datapath
    import llt_pkg::*;
#(
    parameter int SPRITE_SLOTS = SPRITE_SLOTS_DEF,
    parameter int MAX_PER_LINE = MAX_PER_LINE_DEF,
    parameter int LINE_DOTS    = LINE_DOTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    llt_stream_if.sink   req,
    llt_stream_if.source rsp,
    input  llt_cmd_t     cmd,
    output llt_stat_t    stat
);

    localparam int IDX_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
    localparam int CNT_W = $clog2(SPRITE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C    = CNT_W'(SPRITE_SLOTS);
    localparam logic [CNT_W-1:0] LAST_SLOT  = CNT_W'(SPRITE_SLOTS - 1);
    localparam logic [6:0]       SLOTS_IDX  = 7'(SPRITE_SLOTS);
    localparam logic [9:0]       LINE_DOTS_C = 10'(LINE_DOTS);
    localparam logic [3:0]       MAX_C      = 4'(MAX_PER_LINE);

    llt_in_t  in_beat;
    llt_in_t  item_reg;
    llt_out_t out_reg;
    logic     out_valid_reg;

    logic [9:0] sum_reg;
    logic [8:0] dot_reg;
    logic [7:0] line_reg;
    logic [1:0] mode_reg;
    logic       coin_reg;
    logic [3:0] sprites_reg;
    logic [2:0] fine_reg;
    logic       prev_reg;
    logic       fsd_reg;
    logic       pending_reg;
    logic       wrapped_reg;
    logic       vb_reg;
    logic       st_reg;

    logic [7:0]       sprite_mem [SPRITE_SLOTS];
    logic [SPRITE_SLOTS-1:0] slot_valid_reg;
    logic [CNT_W-1:0] issue_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;
    logic             rd_last_reg;
    logic [3:0]       count_reg;
    logic             scan_done_reg;

    logic             load;
    logic             lcd_on;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_fire;
    logic [7:0]       line_inc;
    logic [7:0]       step_line_next;
    logic [1:0]       step_mode_next;
    logic             step_vb;
    logic             window_on;
    logic [9:0]       end3;
    logic [8:0]       dot_final;
    logic [1:0]       mode_next;
    logic             status_cur;
    logic [8:0]       scan_line;
    logic [8:0]       sprite_h;
    logic             hit;
    logic [3:0]       count_next;

    assign in_beat   = req.payload;
    assign req.ready = cmd.ready;
    assign load      = req.valid && cmd.ready;
    assign lcd_on    = item_reg.lcd_control[LCDC_ON];
    assign wr_en     = load && (in_beat.cmd == CMD_SPRITE_WR)
                       && ({1'b0, in_beat.sprite_index} < SLOTS_IDX);
    assign wr_idx    = in_beat.sprite_index[IDX_W-1:0];
    assign rd_idx    = issue_reg[IDX_W-1:0];
    assign rd_fire   = cmd.scan_run && (issue_reg < SLOTS_C);

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    assign stat.req_valid   = req.valid;
    assign stat.req_is_tick = (in_beat.cmd == CMD_TICK);
    assign stat.over_line   = (sum_reg >= LINE_DOTS_C);
    assign stat.need_sample = lcd_on && (line_reg < VBLANK_LINE)
                              && (wrapped_reg || pending_reg);
    assign stat.scan_done   = scan_done_reg;
    assign stat.out_free    = !out_valid_reg || rsp.ready;

    always_comb
    begin
        line_inc       = line_reg + 8'd1;
        step_line_next = line_inc;
        step_mode_next = MODE_VBLANK;
        step_vb        = (line_inc == VBLANK_LINE);
        if (line_inc < VBLANK_LINE)
        begin
            step_mode_next = MODE_OAM;
        end
        else if (line_inc >= FRAME_LINES)
        begin
            step_line_next = 8'd0;
        end
    end

    always_comb
    begin
        window_on = item_reg.lcd_control[LCDC_WIN] && item_reg.lcd_control[LCDC_BG]
                    && (line_reg >= item_reg.window_y)
                    && (item_reg.window_x < WINDOW_X_LIMIT);
        end3 = XFER_BASE + {7'd0, fine_reg} + {4'd0, sprites_reg, 2'b00}
               + {5'd0, sprites_reg, 1'b0} + (window_on ? WINDOW_PENALTY : 10'd0);
        dot_final = sum_reg[8:0];
        mode_next = mode_reg;
        if (line_reg < VBLANK_LINE)
        begin
            if (dot_final < OAM_DOTS)
            begin
                mode_next = MODE_OAM;
            end
            else if ({1'b0, dot_final} < end3)
            begin
                mode_next = MODE_XFER;
            end
            else
            begin
                mode_next = MODE_HBLANK;
            end
        end
        status_cur = ((mode_next == MODE_HBLANK) && item_reg.stat_enables[STAT_EN_M0])
                     || ((mode_next == MODE_VBLANK) && item_reg.stat_enables[STAT_EN_M1])
                     || ((mode_next == MODE_OAM) && item_reg.stat_enables[STAT_EN_M2])
                     || (coin_reg && item_reg.stat_enables[STAT_EN_COIN]);
    end

    always_comb
    begin
        scan_line = {1'b0, line_reg} + SPRITE_Y_OFS;
        sprite_h  = item_reg.lcd_control[LCDC_TALL] ? SPRITE_H_TALL : SPRITE_H_SHORT;
        hit       = ({1'b0, rd_data_reg} <= scan_line)
                    && ((scan_line - {1'b0, rd_data_reg}) < sprite_h);
        count_next = (hit && (count_reg < MAX_C)) ? count_reg + 4'd1 : count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_beat;
        end
        if (wr_en)
        begin
            sprite_mem[wr_idx] <= in_beat.obj_ypos;
        end
        if (rd_fire)
        begin
            rd_data_reg <= slot_valid_reg[rd_idx] ? sprite_mem[rd_idx] : 8'd0;
        end
        if (cmd.publish)
        begin
            out_reg.line         <= line_reg;
            out_reg.mode         <= mode_reg;
            out_reg.coincidence  <= coin_reg;
            out_reg.dot_position <= dot_reg;
            out_reg.vblank_irq   <= vb_reg;
            out_reg.stat_irq     <= st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            dot_reg        <= '0;
            line_reg       <= '0;
            mode_reg       <= MODE_HBLANK;
            coin_reg       <= 1'b0;
            sprites_reg    <= '0;
            fine_reg       <= '0;
            prev_reg       <= 1'b0;
            fsd_reg        <= 1'b0;
            pending_reg    <= 1'b0;
            wrapped_reg    <= 1'b0;
            vb_reg         <= 1'b0;
            st_reg         <= 1'b0;
            slot_valid_reg <= '0;
            issue_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            count_reg      <= '0;
            scan_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                vb_reg      <= 1'b0;
                st_reg      <= 1'b0;
                wrapped_reg <= 1'b0;
                pending_reg <= (in_beat.cmd == CMD_TICK) && in_beat.lcd_control[LCDC_ON]
                               && !fsd_reg && (line_reg < VBLANK_LINE);
                sum_reg     <= {1'b0, dot_reg} + {1'b0, in_beat.dots};
                case (in_beat.cmd)
                    CMD_TICK:
                    begin
                        if (in_beat.lcd_control[LCDC_ON])
                        begin
                            fsd_reg <= 1'b1;
                        end
                        else
                        begin
                            if (line_reg != 8'd0)
                            begin
                                fsd_reg <= 1'b0;
                            end
                            line_reg <= 8'd0;
                            mode_reg <= MODE_HBLANK;
                            prev_reg <= 1'b0;
                        end
                    end
                    CMD_SPRITE_WR:
                    begin
                        if (wr_en)
                        begin
                            slot_valid_reg[wr_idx] <= 1'b1;
                        end
                    end
                    CMD_LCD_ON:
                    begin
                        dot_reg <= LCD_ON_DOT;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.step)
            begin
                sum_reg <= sum_reg - LINE_DOTS_C;
                if (lcd_on)
                begin
                    line_reg    <= step_line_next;
                    mode_reg    <= step_mode_next;
                    coin_reg    <= (step_line_next == item_reg.compare_line);
                    fsd_reg     <= 1'b0;
                    wrapped_reg <= 1'b1;
                    if (step_vb)
                    begin
                        vb_reg <= 1'b1;
                    end
                end
            end

            if (cmd.eval)
            begin
                dot_reg <= dot_final;
                if (lcd_on)
                begin
                    mode_reg <= mode_next;
                    st_reg   <= status_cur && !prev_reg;
                    prev_reg <= status_cur;
                end
            end

            rd_valid_reg <= rd_fire;
            if (rd_fire)
            begin
                issue_reg   <= issue_reg + CNT_W'(1);
                rd_last_reg <= (issue_reg == LAST_SLOT);
            end
            if (rd_valid_reg)
            begin
                count_reg <= count_next;
                if (rd_last_reg)
                begin
                    sprites_reg   <= count_next;
                    fine_reg      <= item_reg.bg_scroll[2:0];
                    scan_done_reg <= 1'b1;
                end
            end
            if (cmd.scan_start)
            begin
                issue_reg     <= '0;
                count_reg     <= '0;
                rd_last_reg   <= 1'b0;
                scan_done_reg <= 1'b0;
            end

            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_dot_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, dot_reg} < LINE_DOTS_C)
        else $error("dot counter left the line");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < FRAME_LINES)
        else $error("line count beyond the frame");

    a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg >= VBLANK_LINE |-> mode_reg == MODE_VBLANK)
        else $error("blanking line without vblank mode");

    a_sprite_cap: assert property (@(posedge clk) disable iff (!rst_n)
        sprites_reg <= MAX_C && count_reg <= MAX_C)
        else $error("sprite count above per-line limit");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready && !cmd.publish |=> out_valid_reg)
        else $error("pending result dropped");

endmodule

[verif/lcd_line_timing_and_stat_irq_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lcd_line_timing_and_stat_irq: a timing predictor checks
// every rsp beat. Depends on llt_pkg, llt_stream_if and the block's RTL.
module lcd_line_timing_and_stat_irq_test;
    import llt_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SPRITE_PENALTY = 6;
    localparam int HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_PER_PHASE = 270;

    logic clk;
    logic rst_n;

    llt_stream_if #(.payload_t(llt_in_t))  req_ch ();
    llt_stream_if #(.payload_t(llt_out_t)) rsp_ch ();

    lcd_line_timing_and_stat_irq u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    llt_in_t  pending_beats[$];
    llt_out_t expected_status[$];
    llt_out_t want;

    int send_idle_pct;
    int recv_idle_pct;
    int beats_pushed;
    int beats_out;
    int errors;
    int vblank_seen;
    int stat_seen;
    int top_line;
    int cycle_count;
    int hold_left;
    bit hold_done;

    int         dot_no;
    int         line_no;
    logic [1:0] mode_now;
    bit         coin_now;
    bit         stat_prev;
    bit         sampled;
    int         sprites_seen;
    logic [2:0] fine_x;
    logic [7:0] obj_ypos_mem[SPRITE_SLOTS_DEF];

    function automatic void sample_line(int ln, logic [7:0] lcdc, logic [7:0] sx);
        int height;
        int n;
        int top;
        height = lcdc[LCDC_TALL] ? int'(SPRITE_H_TALL) : int'(SPRITE_H_SHORT);
        n = 0;
        for (int i = 0; i < SPRITE_SLOTS_DEF && n < MAX_PER_LINE_DEF; i++)
        begin
            top = int'(obj_ypos_mem[i]) - int'(SPRITE_Y_OFS);
            if (ln >= top && ln < top + height)
                n++;
        end
        sprites_seen = n;
        fine_x = sx[2:0];
    endfunction

    function automatic llt_out_t step_timing(llt_in_t b);
        llt_out_t r;
        int end3;
        bit level;
        r = '0;
        case (b.cmd)
            CMD_TICK:
            begin
                if (!b.lcd_control[LCDC_ON])
                begin
                    if (line_no != 0)
                        sampled = 0;
                    line_no = 0;
                    mode_now = MODE_HBLANK;
                    dot_no = (dot_no + int'(b.dots)) % LINE_DOTS_DEF;
                    stat_prev = 0;
                end
                else
                begin
                    if (!sampled)
                    begin
                        sampled = 1;
                        if (line_no < int'(VBLANK_LINE))
                            sample_line(line_no, b.lcd_control, b.bg_scroll);
                    end
                    dot_no += int'(b.dots);
                    while (dot_no >= LINE_DOTS_DEF)
                    begin
                        dot_no -= LINE_DOTS_DEF;
                        line_no++;
                        sampled = 0;
                        if (line_no < int'(VBLANK_LINE))
                        begin
                            sample_line(line_no, b.lcd_control, b.bg_scroll);
                            mode_now = MODE_OAM;
                        end
                        else if (line_no == int'(VBLANK_LINE))
                        begin
                            r.vblank_irq = 1'b1;
                            mode_now = MODE_VBLANK;
                        end
                        else if (line_no >= int'(FRAME_LINES))
                        begin
                            line_no = 0;
                            sample_line(0, b.lcd_control, b.bg_scroll);
                            mode_now = MODE_VBLANK;
                        end
                        else
                        begin
                            mode_now = MODE_VBLANK;
                        end
                        coin_now = (line_no == int'(b.compare_line));
                    end
                    if (line_no < int'(VBLANK_LINE))
                    begin
                        end3 = int'(XFER_BASE) + int'(fine_x) + sprites_seen * SPRITE_PENALTY;
                        if (b.lcd_control[LCDC_WIN] && b.lcd_control[LCDC_BG]
                                && line_no >= int'(b.window_y) && b.window_x < WINDOW_X_LIMIT)
                            end3 += int'(WINDOW_PENALTY);
                        if (dot_no < int'(OAM_DOTS))
                            mode_now = MODE_OAM;
                        else if (dot_no < end3)
                            mode_now = MODE_XFER;
                        else
                            mode_now = MODE_HBLANK;
                    end
                    level = (mode_now == MODE_HBLANK && b.stat_enables[STAT_EN_M0])
                        || (mode_now == MODE_VBLANK && b.stat_enables[STAT_EN_M1])
                        || (mode_now == MODE_OAM && b.stat_enables[STAT_EN_M2])
                        || (coin_now && b.stat_enables[STAT_EN_COIN]);
                    if (level && !stat_prev)
                        r.stat_irq = 1'b1;
                    stat_prev = level;
                end
            end
            CMD_SPRITE_WR:
            begin
                if (int'(b.sprite_index) < SPRITE_SLOTS_DEF)
                    obj_ypos_mem[b.sprite_index] = b.obj_ypos;
            end
            CMD_LCD_ON:
            begin
                dot_no = int'(LCD_ON_DOT);
            end
            default:
            begin
            end
        endcase
        r.line = line_no[7:0];
        r.mode = mode_now;
        r.coincidence = coin_now;
        r.dot_position = dot_no[8:0];
        return r;
    endfunction

    function automatic llt_in_t tick_beat(int dots, logic [7:0] lcdc, logic [7:0] lyc,
                                          logic [3:0] en, logic [7:0] wy, logic [7:0] wx,
                                          logic [7:0] sx);
        llt_in_t b;
        b = '0;
        b.cmd = CMD_TICK;
        b.dots = dots[8:0];
        b.lcd_control = lcdc;
        b.compare_line = lyc;
        b.stat_enables = en;
        b.window_y = wy;
        b.window_x = wx;
        b.bg_scroll = sx;
        return b;
    endfunction

    function automatic llt_in_t command_beat(logic [1:0] cmd, int idx, logic [7:0] y);
        llt_in_t b;
        b = '0;
        b.cmd = cmd;
        b.sprite_index = idx[5:0];
        b.obj_ypos = y;
        return b;
    endfunction

    function automatic llt_in_t random_beat();
        llt_in_t b;
        int pick;
        b.cmd = CMD_TICK;
        b.dots = 9'($urandom_range(511));
        b.lcd_control = 8'($urandom_range(255));
        b.compare_line = 8'($urandom_range(255));
        b.stat_enables = 4'($urandom_range(15));
        b.window_y = 8'($urandom_range(255));
        b.window_x = 8'($urandom_range(255));
        b.bg_scroll = 8'($urandom_range(255));
        b.sprite_index = 6'($urandom_range(63));
        b.obj_ypos = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            b.cmd = CMD_SPRITE_WR;
            b.sprite_index = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 40))
                                                     : 6'($urandom_range(39));
            b.obj_ypos = $urandom_range(1) ? 8'($urandom_range(44, 14))
                                           : 8'($urandom_range(255));
        end
        else if (pick < 10)
        begin
            b.cmd = CMD_LCD_ON;
        end
        else if (pick < 12)
        begin
            b.cmd = CMD_UNUSED;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                b.dots = 9'($urandom_range(16));
            else if (pick < 90)
                b.dots = 9'($urandom_range(455, 200));
            else
                b.dots = 9'($urandom_range(511, 456));
            b.lcd_control[LCDC_ON] = ($urandom_range(399) != 0);
            if ($urandom_range(9) < 7)
                b.compare_line = 8'($urandom_range(153));
            if ($urandom_range(1))
                b.window_y = 8'($urandom_range(143));
        end
        return b;
    endfunction

    task automatic queue_beat(llt_in_t b);
        pending_beats.push_back(b);
        beats_pushed++;
    endtask

    task automatic wait_drained();
        while (beats_out != beats_pushed)
            @(posedge clk);
    endtask

    task automatic check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                     actual);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d of %0d beats returned.", cycle_count,
                     beats_out, beats_pushed);
            $display("lcd_line_timing_and_stat_irq_test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                expected_status.push_back(step_timing(req_ch.payload));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.payload <= pending_beats.pop_front();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // The long hold-off lets the block fill up and back-pressure req.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && beats_out >= 100)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            beats_out++;
            if (rsp_ch.payload.vblank_irq)
                vblank_seen++;
            if (rsp_ch.payload.stat_irq)
                stat_seen++;
            if (int'(rsp_ch.payload.line) > top_line)
                top_line = int'(rsp_ch.payload.line);
            if (expected_status.size() == 0)
            begin
                errors++;
                $display("%0t: beat with nothing expected, actual %p", $time, rsp_ch.payload);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("line", want.line, rsp_ch.payload.line);
                check_field("mode", want.mode, rsp_ch.payload.mode);
                check_field("coincidence", want.coincidence, rsp_ch.payload.coincidence);
                check_field("dot_position", want.dot_position, rsp_ch.payload.dot_position);
                check_field("vblank_irq", want.vblank_irq, rsp_ch.payload.vblank_irq);
                check_field("stat_irq", want.stat_irq, rsp_ch.payload.stat_irq);
            end
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        rst_n = 1'b0;
        dot_no = 0;
        line_no = 0;
        mode_now = MODE_HBLANK;
        coin_now = 0;
        stat_prev = 0;
        sampled = 0;
        sprites_seen = 0;
        fine_x = '0;
        foreach (obj_ypos_mem[i])
            obj_ypos_mem[i] = '0;
        send_idle_pct = 16;
        recv_idle_pct = 88;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Off ticks, writes in and out of range, window and tall sprites, line crossings.
        queue_beat(tick_beat(455, 8'h00, 8'd0, 4'hF, 8'd0, 8'd7, 8'h00));
        queue_beat(command_beat(CMD_LCD_ON, 0, 8'h00));
        queue_beat(command_beat(CMD_SPRITE_WR, 0, 8'd16));
        queue_beat(command_beat(CMD_SPRITE_WR, 1, 8'd8));
        queue_beat(command_beat(CMD_SPRITE_WR, 39, 8'hFF));
        queue_beat(command_beat(CMD_SPRITE_WR, 40, 8'hAA));
        queue_beat(command_beat(CMD_SPRITE_WR, 63, 8'h55));
        queue_beat(command_beat(CMD_UNUSED, 63, 8'hFF));
        queue_beat(tick_beat(0, 8'hA5, 8'd1, 4'hF, 8'd0, 8'd7, 8'hFF));
        queue_beat(tick_beat(80, 8'hA5, 8'd1, 4'hF, 8'd0, 8'd7, 8'hFF));
        queue_beat(tick_beat(196, 8'hA5, 8'd1, 4'hF, 8'd0, 8'd7, 8'hFF));
        queue_beat(tick_beat(1, 8'hA5, 8'd1, 4'hF, 8'd0, 8'd7, 8'hFF));
        queue_beat(tick_beat(179, 8'hA5, 8'd1, 4'hF, 8'd0, 8'd7, 8'hFF));
        queue_beat(tick_beat(511, 8'hA5, 8'd2, 4'h8, 8'd0, 8'd167, 8'h00));
        queue_beat(tick_beat(100, 8'h7F, 8'd0, 4'hF, 8'd0, 8'd7, 8'h00));
        queue_beat(command_beat(CMD_LCD_ON, 0, 8'h00));
        queue_beat(tick_beat(0, 8'h80, 8'd0, 4'h8, 8'd0, 8'd0, 8'h00));
        queue_beat(tick_beat(511, 8'hFF, 8'd255, 4'h1, 8'd255, 8'd255, 8'hFF));
        queue_beat(tick_beat(0, 8'h81, 8'd0, 4'h4, 8'd0, 8'd166, 8'h00));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 16 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                queue_beat(random_beat());
            wait_drained();
        end

        repeat (100) @(posedge clk);
        $display("Checked %0d beats over three flow-control phases; highest line %0d.",
                 beats_out, top_line);
        $display("Saw %0d vblank and %0d STAT pulses; %0d mismatches.", vblank_seen,
                 stat_seen, errors);
        if (errors == 0 && expected_status.size() == 0)
            $display("lcd_line_timing_and_stat_irq_test passed");
        else
            $display("lcd_line_timing_and_stat_irq_test failed");
        $finish;
    end

endmodule
